// ===== sv/linear_scan_key_handle_table_unit_macros.svh =====
// ---------------------------------------------------------------------------
// linear scan key handle table - assertion macros
// shared concurrent assertion forms for the table's rtl modules
// ---------------------------------------------------------------------------
`ifndef LINEAR_SCAN_KEY_HANDLE_TABLE_UNIT_MACROS_SVH
`define LINEAR_SCAN_KEY_HANDLE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, masked while reset is held
`define LSKHT_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, masked while reset is held
`define LSKHT_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/lskht_pkg.sv =====
// ---------------------------------------------------------------------------
// lskht_pkg
// types, codes and defaults shared by the key handle table modules
// ---------------------------------------------------------------------------
package lskht_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_WIDTH_DEF   = 64;

  localparam int OP_W     = 2;
  localparam int FKEY_W   = 64;
  localparam int HANDLE_W = 64;
  localparam int LIDX_W   = 8;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_FIND = 2'd1,
    OP_NEXT = 2'd2,
    OP_DEL  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_END      = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, set scan start
    logic clr;       // clear one valid mark
    logic scan;      // issue one table read
    logic commit;    // write new entry into free slot
    logic out_load;  // move pending result to output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic past_end;
    logic done;
    logic need_commit;
  } sts_t;

endpackage

// ===== sv/lskht_ram.sv =====
// ---------------------------------------------------------------------------
// lskht_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module lskht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== sv/lskht_dp.sv =====
// ---------------------------------------------------------------------------
// lskht_dp
// request registers, scan address, table memories and result registers
// ---------------------------------------------------------------------------
`include "linear_scan_key_handle_table_unit_macros.svh"

module lskht_dp #(
  parameter int TABLE_DEPTH = lskht_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = lskht_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lskht_pkg::cmd_t               cmd,
  output lskht_pkg::sts_t               sts,
  input  logic [lskht_pkg::OP_W-1:0]     in_op,
  input  logic [lskht_pkg::FKEY_W-1:0]   in_key_in,
  input  logic [lskht_pkg::HANDLE_W-1:0] in_handle_in,
  input  logic                          in_from_start,
  input  logic [lskht_pkg::LIDX_W-1:0]   in_last_index,
  output logic [lskht_pkg::STATUS_W-1:0] out_status,
  output logic [lskht_pkg::HANDLE_W-1:0] out_handle_out,
  output logic [lskht_pkg::FKEY_W-1:0]   out_key_out,
  output logic [lskht_pkg::LIDX_W-1:0]   out_index_out
);

  import lskht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  op_t                 op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [CNT_W-1:0]    addr_r;
  logic                past_end_r;
  logic                data_vld_r;
  logic [IDX_W-1:0]    data_idx_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;
  status_t             pend_status_r;
  logic [IDX_W-1:0]    pend_idx_r;

  logic [STATUS_W-1:0] out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [FKEY_W-1:0]   out_key_r;
  logic [LIDX_W-1:0]   out_index_r;

  logic [LIDX_W:0]     start_w;
  logic                start_past;
  logic                rd_issue;
  logic                vrd;
  logic [KEY_WIDTH-1:0] krd;
  logic [HANDLE_W-1:0] hrd;
  logic                hit;
  logic                last;
  logic                done;
  logic                free_any;
  logic                del_wr;
  logic                vwe;
  logic [IDX_W-1:0]    vwaddr;
  logic                vwdata;
  logic                res_data;
  logic                res_next;
  logic [KEY_WIDTH+FKEY_W-1:0] key_ext;
  logic [IDX_W+LIDX_W-1:0]     idx_ext;

  // scan start for next
  assign start_w    = in_from_start ? '0 : ({1'b0, in_last_index} + 1'b1);
  assign start_past = (int'(start_w) >= TABLE_DEPTH);

  assign rd_issue = cmd.scan && (addr_r < CNT_W'(TABLE_DEPTH));

  assign hit  = data_vld_r && vrd && ((op_r == OP_NEXT) || (krd == key_r));
  assign last = (data_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign done = data_vld_r && (hit || last);
  assign free_any = free_found_r || (data_vld_r && !vrd);
  assign del_wr   = done && hit && (op_r == OP_DEL);

  assign sts.clr_last    = (addr_r == CNT_W'(TABLE_DEPTH - 1));
  assign sts.past_end    = past_end_r;
  assign sts.done        = done;
  assign sts.need_commit = done && (op_r == OP_ADD) && !hit && free_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= '0;
      data_vld_r   <= 1'b0;
      free_found_r <= 1'b0;
      past_end_r   <= 1'b0;
    end else begin
      priority if (cmd.load) begin
        // only next starts part way; add, find and delete scan from entry zero
        addr_r     <= ((op_t'(in_op) == OP_NEXT) && !start_past) ? CNT_W'(start_w) : '0;
        past_end_r <= (op_t'(in_op) == OP_NEXT) && start_past;
      end else if (cmd.clr || rd_issue) begin
        addr_r <= addr_r + 1'b1;
      end
      data_vld_r <= rd_issue;
      if (cmd.load) begin
        free_found_r <= 1'b0;
      end else if (data_vld_r && !vrd && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r          <= op_t'(in_op);
      key_r         <= in_key_in[KEY_WIDTH-1:0];
      handle_r      <= in_handle_in;
      pend_status_r <= ST_END;
    end
    if (rd_issue) begin
      data_idx_r <= addr_r[IDX_W-1:0];
    end
    if (data_vld_r && !vrd && !free_found_r) begin
      free_idx_r <= data_idx_r;
    end
    if (done) begin
      pend_idx_r <= data_idx_r;
      unique case (op_r)
        OP_ADD:  pend_status_r <= hit ? ST_EXISTS : (free_any ? ST_OK : ST_FULL);
        OP_FIND: pend_status_r <= hit ? ST_OK : ST_NOTFOUND;
        OP_NEXT: pend_status_r <= hit ? ST_OK : ST_END;
        OP_DEL:  pend_status_r <= hit ? ST_OK : ST_NOTFOUND;
        default: pend_status_r <= ST_NOTFOUND;
      endcase
    end
  end

  // valid mark write port: clearing pass, new entry, delete
  always_comb begin
    vwe    = 1'b0;
    vwaddr = addr_r[IDX_W-1:0];
    vwdata = 1'b0;
    priority if (cmd.clr) begin
      vwe = 1'b1;
    end else if (cmd.commit) begin
      vwe    = 1'b1;
      vwaddr = free_idx_r;
      vwdata = 1'b1;
    end else if (del_wr) begin
      vwe    = 1'b1;
      vwaddr = data_idx_r;
    end
  end

  lskht_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (vwaddr),
    .wdata (vwdata),
    .re    (rd_issue),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (vrd)
  );

  lskht_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (free_idx_r),
    .wdata (key_r),
    .re    (rd_issue),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (krd)
  );

  lskht_ram #(.WIDTH(HANDLE_W), .DEPTH(TABLE_DEPTH)) u_handle_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (free_idx_r),
    .wdata (handle_r),
    .re    (rd_issue),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (hrd)
  );

  // read data holds the matched entry until the next scan
  assign res_data = (pend_status_r == ST_OK) && ((op_r == OP_FIND) || (op_r == OP_NEXT));
  assign res_next = (pend_status_r == ST_OK) && (op_r == OP_NEXT);
  assign key_ext  = {{FKEY_W{1'b0}}, krd};
  assign idx_ext  = {{LIDX_W{1'b0}}, pend_idx_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= pend_status_r;
      out_handle_r <= res_data ? hrd : '0;
      out_key_r    <= res_next ? key_ext[FKEY_W-1:0] : '0;
      out_index_r  <= res_next ? idx_ext[LIDX_W-1:0] : '0;
    end
  end

  assign out_status     = out_status_r;
  assign out_handle_out = out_handle_r;
  assign out_key_out    = out_key_r;
  assign out_index_out  = out_index_r;

  `LSKHT_ASSERT_IMP(a_no_read_on_done, clk, rst_n, done, !rd_issue,
    "table read issued while a scan result is being taken")
  `LSKHT_ASSERT_IMP(a_commit_has_slot, clk, rst_n, cmd.commit, free_found_r,
    "entry written without a free slot found")
  `LSKHT_ASSERT_IMP(a_data_follows_read, clk, rst_n, data_vld_r, $past(rd_issue),
    "scan data stage valid without a read the cycle before")

endmodule

// ===== sv/lskht_ctrl.sv =====
// ---------------------------------------------------------------------------
// lskht_ctrl
// sequencer for clearing pass, scan, entry write and result hand-off
// ---------------------------------------------------------------------------
`include "linear_scan_key_handle_table_unit_macros.svh"

module lskht_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  lskht_pkg::sts_t sts,
  output lskht_pkg::cmd_t cmd
);

  import lskht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (sts.past_end) begin
          state_nxt = S_DONE;
        end else if (sts.done) begin
          state_nxt = sts.need_commit ? S_COMMIT : S_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `LSKHT_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_r && out_stall, !cmd.out_load,
    "waiting result overwritten")
  `LSKHT_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall,
    "second request taken while one is in work")
  `LSKHT_ASSERT_IMP(a_commit_after_scan, clk, rst_n, cmd.commit, $past(state_r) == S_SCAN,
    "entry write not preceded by a scan")

endmodule

// ===== sv/linear_scan_key_handle_table_unit.sv =====
// ---------------------------------------------------------------------------
// linear_scan_key_handle_table_unit
// key to handle table searched by linear scan: add, find, next, delete
// ---------------------------------------------------------------------------
//
// channel   dir  handshake            payload
// in_       in   in_valid / in_stall   op, key_in, handle_in, from_start, last_index
// out_      out  out_valid / out_stall status, handle_out, key_out, index_out
//
// after reset a clearing pass zeroes the valid marks, during which no
//   request is taken
// one request at a time: the scan reads one entry a cycle through the key,
//   handle and valid memory read ports, and stops early on a match
// add scans for the key up to a match or the table end; if absent, it writes the first free slot
// a waiting result sits in the output register; the next request is taken
//   meanwhile and its result waits while out_stall is high
// ---------------------------------------------------------------------------
module linear_scan_key_handle_table_unit #(
  parameter int TABLE_DEPTH = lskht_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = lskht_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lskht_pkg::OP_W-1:0]     in_op,
  input  logic [lskht_pkg::FKEY_W-1:0]   in_key_in,
  input  logic [lskht_pkg::HANDLE_W-1:0] in_handle_in,
  input  logic                          in_from_start,
  input  logic [lskht_pkg::LIDX_W-1:0]   in_last_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lskht_pkg::STATUS_W-1:0] out_status,
  output logic [lskht_pkg::HANDLE_W-1:0] out_handle_out,
  output logic [lskht_pkg::FKEY_W-1:0]   out_key_out,
  output logic [lskht_pkg::LIDX_W-1:0]   out_index_out
);

  import lskht_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, scan control, output register valid
  lskht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: memories, scan address, match logic, result registers
  lskht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_key_in      (in_key_in),
    .in_handle_in   (in_handle_in),
    .in_from_start  (in_from_start),
    .in_last_index  (in_last_index),
    .out_status     (out_status),
    .out_handle_out (out_handle_out),
    .out_key_out    (out_key_out),
    .out_index_out  (out_index_out)
  );

endmodule
